// File: hw/rtl/packed_bcd_binary_converter_core_defines.svh
// Assertion macros shared by the converter RTL.
`ifndef PACKED_BCD_BINARY_CONVERTER_CORE_DEFINES_SVH
`define PACKED_BCD_BINARY_CONVERTER_CORE_DEFINES_SVH

// Same-cycle implication.
`define PBC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PBC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/pbc_pkg.sv
`default_nettype none

package pbc_pkg;

  localparam int DATA_W         = 64;
  localparam int CNT_W          = 4;
  localparam int BCD_DIGITS     = 20;
  localparam int BCD_W          = 4 * BCD_DIGITS;
  localparam int DD_STAGES      = 8;
  localparam int BITS_PER_STAGE = DATA_W / DD_STAGES;

  localparam logic CMD_BCD2BIN = 1'b0;
  localparam logic CMD_BIN2BCD = 1'b1;

  typedef struct packed {
    logic [BCD_W-1:0]  bcd;
    logic [DATA_W-1:0] bin;
  } dd_t;

  typedef struct packed {
    logic              cmd;
    logic [CNT_W-1:0]  cnt;
    dd_t               dd;
    logic [DATA_W-1:0] dec;
    logic              ovf;
  } stage_t;

  function automatic logic [DATA_W-1:0] bytes_mask(logic [CNT_W-1:0] n);
    logic [DATA_W-1:0] r;
    r = '0;
    for (int k = 0; k < DATA_W / 8; k++) begin
      r[8*k +: 8] = (CNT_W'(k) < n) ? 8'hff : 8'h00;
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pow100(logic [CNT_W-1:0] n);
    logic [DATA_W-1:0] r;
    case (n)
      4'd0:    r = 64'd1;
      4'd1:    r = 64'd100;
      4'd2:    r = 64'd10000;
      4'd3:    r = 64'd1000000;
      4'd4:    r = 64'd100000000;
      4'd5:    r = 64'd10000000000;
      4'd6:    r = 64'd1000000000000;
      4'd7:    r = 64'd100000000000000;
      default: r = 64'd10000000000000000;
    endcase
    return r;
  endfunction

  // Double dabble, BITS_PER_STAGE shift steps.
  function automatic dd_t dabble_step(dd_t x);
    dd_t r;
    r = x;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (r.bcd[4*d +: 4] >= 4'd5) begin
          r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
        end
      end
      r = dd_t'(r << 1);
    end
    return r;
  endfunction

  // Packed BCD bytes to four 16-bit base-10000 partial sums.
  function automatic logic [DATA_W-1:0] bcd_pairs(logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] r;
    logic [7:0]        v0;
    logic [7:0]        v1;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      v0 = 8'(x[16*k +: 4])      + 8'(x[16*k+4 +: 4])  * 8'd10;
      v1 = 8'(x[16*k+8 +: 4])    + 8'(x[16*k+12 +: 4]) * 8'd10;
      r[16*k +: 16] = 16'(v0) + 16'(v1) * 16'd100;
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] merge_quads(logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] r;
    r = '0;
    for (int k = 0; k < 2; k++) begin
      r[32*k +: 32] = 32'(x[32*k +: 16]) + 32'(x[32*k+16 +: 16]) * 32'd10000;
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] merge_halves(logic [DATA_W-1:0] x);
    return 64'(x[31:0]) + 64'(x[63:32]) * 64'd100000000;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/packed_bcd_binary_converter_core.sv
// Packed BCD <-> binary converter, 64-bit, 0 to 8 bytes in use.
// Request channel: req_valid/req_stall with cmd, byte_count, value.
//   cmd 0 turns packed BCD into binary, cmd 1 turns binary into packed BCD.
//   byte_count above MAX_BYTES is taken as MAX_BYTES.
// Response channel: rsp_valid/rsp_stall with result and overflow.
// A transfer happens on a clock edge with valid high and stall low.
// Throughput: one transfer per cycle while the receiver does not stall; the path
//   holds the input register, eight double-dabble stages of eight bits each, and the output register.
// When the receiver stalls, the response holds and the pipeline fills its
//   empty stages; req_stall rises only once every stage holds an item.
// Reset empties the pipeline; no results are pending after it.
`default_nettype none
`include "packed_bcd_binary_converter_core_defines.svh"

module packed_bcd_binary_converter_core
  import pbc_pkg::*;
#(
  parameter int MAX_BYTES = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output      logic                req_stall,
  input  wire logic                cmd,
  input  wire logic [CNT_W-1:0]    byte_count,
  input  wire logic [DATA_W-1:0]   value,
  output      logic                rsp_valid,
  input  wire logic                rsp_stall,
  output      logic [DATA_W-1:0]   result,
  output      logic                overflow
);

  stage_t                pipe       [0:DD_STAGES];
  stage_t                stage_next [1:DD_STAGES];
  logic [DD_STAGES:0]    pipe_vld;
  logic [DD_STAGES+1:0]  rdy;
  logic [CNT_W-1:0]      cnt_sat;
  logic [DATA_W-1:0]     result_next;

  always_comb begin
    rdy[DD_STAGES+1] = !rsp_valid || !rsp_stall;
    for (int k = DD_STAGES; k >= 0; k--) begin
      rdy[k] = !pipe_vld[k] || rdy[k+1];
    end
  end
  assign req_stall = !rdy[0];

  assign cnt_sat = (byte_count > CNT_W'(MAX_BYTES)) ? CNT_W'(MAX_BYTES) : byte_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      pipe_vld[0] <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pipe[0].cmd    <= cmd;
      pipe[0].cnt    <= cnt_sat;
      pipe[0].dd.bcd <= '0;
      pipe[0].dd.bin <= value & bytes_mask(cnt_sat);
      pipe[0].dec    <= '0;
      pipe[0].ovf    <= 1'b0;
    end
  end

  for (genvar g = 1; g <= DD_STAGES; g++) begin : g_stage
    always_comb begin
      stage_next[g].cmd = pipe[g-1].cmd;
      stage_next[g].cnt = pipe[g-1].cnt;
      stage_next[g].dd  = dabble_step(pipe[g-1].dd);
      case (g)
        1:       stage_next[g].dec = bcd_pairs(pipe[g-1].dd.bin);
        2:       stage_next[g].dec = merge_quads(pipe[g-1].dec);
        3:       stage_next[g].dec = merge_halves(pipe[g-1].dec);
        default: stage_next[g].dec = pipe[g-1].dec;
      endcase
      if (g == 1) begin
        stage_next[g].ovf = (pipe[g-1].cmd == CMD_BIN2BCD) &&
                            (pipe[g-1].dd.bin >= pow100(pipe[g-1].cnt));
      end else begin
        stage_next[g].ovf = pipe[g-1].ovf;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe_vld[g] <= 1'b0;
      end else if (rdy[g]) begin
        pipe_vld[g] <= pipe_vld[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[g]) begin
        pipe[g] <= stage_next[g];
      end
    end
  end

  assign result_next = ((pipe[DD_STAGES].cmd == CMD_BIN2BCD) ?
                        pipe[DD_STAGES].dd.bcd[DATA_W-1:0] : pipe[DD_STAGES].dec) &
                       bytes_mask(pipe[DD_STAGES].cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rdy[DD_STAGES+1]) begin
      rsp_valid <= pipe_vld[DD_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[DD_STAGES+1]) begin
      result   <= result_next;
      overflow <= pipe[DD_STAGES].ovf;
    end
  end

  `PBC_ASSERT_NOW(a_stall_only_when_full, clk, rst, req_stall, (&pipe_vld) && rsp_valid && rsp_stall, "request stalled with room in the pipeline")
  `PBC_ASSERT_NEXT(a_last_stage_holds, clk, rst, pipe_vld[DD_STAGES] && rsp_valid && rsp_stall, pipe_vld[DD_STAGES] && $stable(pipe[DD_STAGES]), "last stage changed while response stalled")
  `PBC_ASSERT_NOW(a_ovf_only_bin2bcd, clk, rst, pipe_vld[1] && pipe[1].ovf, pipe[1].cmd == CMD_BIN2BCD, "overflow raised for BCD to binary")

endmodule

`default_nettype wire

// File: bench/tb_packed_bcd_binary_converter_core.sv
`default_nettype none

module tb_packed_bcd_binary_converter_core;
  import pbc_pkg::*;

  localparam int MAX_BYTES = 8;
  localparam int N_RANDOM  = 650;
  localparam int LIMIT     = 200000;
  localparam int QUIET_LO  = 300;
  localparam int QUIET_HI  = 600;
  localparam int DRAIN     = 30;

  typedef struct {
    logic              cmd;
    logic [CNT_W-1:0]  cnt;
    logic [DATA_W-1:0] val;
    bit                hold;
  } conv_req_t;

  typedef struct {
    logic [DATA_W-1:0] result;
    logic              overflow;
  } conv_rsp_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  logic              cmd = CMD_BCD2BIN;
  logic [CNT_W-1:0]  byte_count = '0;
  logic [DATA_W-1:0] value = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  logic [DATA_W-1:0] result;
  logic              overflow;

  conv_req_t pending_reqs[$];
  conv_rsp_t expected_rsps[$];

  int cycles = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_errors = 0;
  int n_to_bin = 0;
  int n_to_bcd = 0;
  int n_ovf = 0;
  int n_holds = 0;
  bit quiet;

  packed_bcd_binary_converter_core #(
    .MAX_BYTES(MAX_BYTES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .cmd(cmd),
    .byte_count(byte_count),
    .value(value),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .result(result),
    .overflow(overflow)
  );

  always #5 clk = ~clk;

  function automatic conv_rsp_t convert_packed_bcd(logic op, logic [CNT_W-1:0] cnt,
                                                    logic [DATA_W-1:0] val);
    conv_rsp_t         r;
    int                n;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] src;
    logic [DATA_W-1:0] weight;
    logic [DATA_W-1:0] d;
    logic [7:0]        b;
    n = (cnt > MAX_BYTES) ? MAX_BYTES : int'(cnt);
    mask = (n >= 8) ? {DATA_W{1'b1}} : ((64'd1 << (8 * n)) - 64'd1);
    src = val & mask;
    r.result = '0;
    r.overflow = 1'b0;
    if (op == CMD_BCD2BIN) begin
      weight = 64'd1;
      for (int i = 0; i < n; i++) begin
        b = src[8*i +: 8];
        r.result = r.result + (64'(b[3:0]) + 64'(b[7:4]) * 64'd10) * weight;
        weight = weight * 64'd100;
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        d = src % 64'd100;
        r.result = r.result | ((((d / 64'd10) << 4) | (d % 64'd10)) << (8 * i));
        src = src / 64'd100;
      end
      r.overflow = (src != 0);
    end
    r.result = r.result & mask;
    return r;
  endfunction

  function automatic conv_req_t mk_req(logic op, logic [CNT_W-1:0] cnt,
                                       logic [DATA_W-1:0] val, bit hold);
    conv_req_t r;
    r.cmd = op;
    r.cnt = cnt;
    r.val = val;
    r.hold = hold;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_value(logic op);
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] p;
    int                m;
    v = {$urandom, $urandom};
    case ($urandom_range(3))
      1, 2: begin
        if (op == CMD_BCD2BIN) begin
          for (int k = 0; k < 16; k++) v[4*k +: 4] = 4'($urandom_range(9));
        end else begin
          m = $urandom_range(9, 1);
          p = 64'd1;
          for (int k = 0; k < m; k++) p = p * 64'd100;
          v = p + 64'($urandom_range(4)) - 64'd2;
        end
      end
      3: v = v >> $urandom_range(63);
      default: ;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] exp_v,
                                 logic [DATA_W-1:0] got_v);
    $display("ERROR @%0d rsp %0d: %s expected %h got %h", cycles, n_recv, what, exp_v, got_v);
    n_errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Timeout after %0d cycles, %0d of %0d responses", cycles, n_recv, n_sent);
      $display("Simulation FAILED");
      $finish;
    end
  end

  assign quiet = (cycles >= QUIET_LO) && (cycles < QUIET_HI);

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_rsps.push_back(convert_packed_bcd(cmd, byte_count, value));
        n_sent <= n_sent + 1;
        if (cmd == CMD_BCD2BIN) n_to_bin++;
        else n_to_bcd++;
      end
      if (!req_valid || !req_stall) begin
        if (pending_reqs.size() == 0 || (!quiet && $urandom_range(99) < 19)) begin
          req_valid <= 1'b0;
        end else if (pending_reqs[0].hold && (req_valid || n_sent != n_recv)) begin
          req_valid <= 1'b0;
        end else begin
          if (pending_reqs[0].hold) n_holds++;
          req_valid <= 1'b1;
          cmd <= pending_reqs[0].cmd;
          byte_count <= pending_reqs[0].cnt;
          value <= pending_reqs[0].val;
          void'(pending_reqs.pop_front());
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    conv_rsp_t exp_r;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        n_recv <= n_recv + 1;
        if (overflow === 1'b1) n_ovf++;
        if (n_recv >= n_sent) begin
          report_mismatch("unexpected transfer, result", '0, result);
        end else begin
          exp_r = expected_rsps.pop_front();
          if (result !== exp_r.result) report_mismatch("result", exp_r.result, result);
          if (overflow !== exp_r.overflow) report_mismatch("overflow", 64'(exp_r.overflow),
                                                           64'(overflow));
        end
      end
      rsp_stall <= !quiet && ($urandom_range(99) < 19);
    end
  end

  initial begin
    conv_req_t it;

    pending_reqs.push_back(mk_req(CMD_BCD2BIN, 4'd8, 64'h9999_9999_9999_9999, 1'b0));
    pending_reqs.push_back(mk_req(CMD_BCD2BIN, 4'd8, 64'hffff_ffff_ffff_ffff, 1'b0));
    pending_reqs.push_back(mk_req(CMD_BCD2BIN, 4'd8, 64'h0, 1'b0));
    pending_reqs.push_back(mk_req(CMD_BCD2BIN, 4'd1, 64'hffff_ffff_ffff_ffff, 1'b0));
    pending_reqs.push_back(mk_req(CMD_BCD2BIN, 4'd1, 64'h0000_0000_0000_00a5, 1'b0));
    pending_reqs.push_back(mk_req(CMD_BCD2BIN, 4'd4, 64'hdead_beef_1234_5678, 1'b0));
    pending_reqs.push_back(mk_req(CMD_BCD2BIN, 4'd0, 64'h1234_5678_9012_3456, 1'b0));
    pending_reqs.push_back(mk_req(CMD_BCD2BIN, 4'd15, 64'h1234_5678_9012_3456, 1'b0));
    pending_reqs.push_back(mk_req(CMD_BCD2BIN, 4'd9, 64'hffff_ffff_ffff_ffff, 1'b0));
    pending_reqs.push_back(mk_req(CMD_BIN2BCD, 4'd8, 64'hffff_ffff_ffff_ffff, 1'b0));
    pending_reqs.push_back(mk_req(CMD_BIN2BCD, 4'd8, 64'd9999999999999999, 1'b0));
    pending_reqs.push_back(mk_req(CMD_BIN2BCD, 4'd8, 64'd10000000000000000, 1'b0));
    pending_reqs.push_back(mk_req(CMD_BIN2BCD, 4'd8, 64'h0, 1'b0));
    pending_reqs.push_back(mk_req(CMD_BIN2BCD, 4'd1, 64'd99, 1'b0));
    pending_reqs.push_back(mk_req(CMD_BIN2BCD, 4'd1, 64'd100, 1'b0));
    pending_reqs.push_back(mk_req(CMD_BIN2BCD, 4'd2, 64'hffff_ffff_ffff_0063, 1'b0));
    pending_reqs.push_back(mk_req(CMD_BIN2BCD, 4'd2, 64'h0000_0000_0000_ffff, 1'b0));
    pending_reqs.push_back(mk_req(CMD_BIN2BCD, 4'd0, 64'hffff_ffff_ffff_ffff, 1'b0));
    pending_reqs.push_back(mk_req(CMD_BIN2BCD, 4'd15, 64'hffff_ffff_ffff_ffff, 1'b0));
    pending_reqs.push_back(mk_req(CMD_BIN2BCD, 4'd12, 64'd12345678901234567, 1'b0));
    pending_reqs.push_back(mk_req(CMD_BIN2BCD, 4'd7, 64'd99999999999999, 1'b0));
    pending_reqs.push_back(mk_req(CMD_BIN2BCD, 4'd7, 64'd100000000000000, 1'b0));

    for (int k = 0; k < N_RANDOM; k++) begin
      it.cmd = logic'($urandom_range(1));
      it.cnt = ($urandom_range(9) == 0) ? CNT_W'($urandom_range(15))
                                        : CNT_W'($urandom_range(8, 1));
      it.val = rand_value(it.cmd);
      it.hold = (k == 0) || ($urandom_range(99) == 0);
      pending_reqs.push_back(it);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_valid) @(posedge clk);
    while (n_recv != n_sent) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (expected_rsps.size() != 0) begin
      $display("ERROR: %0d responses never arrived", expected_rsps.size());
      n_errors++;
    end
    $display("Covered %0d BCD-to-binary and %0d binary-to-BCD transfers, %0d overflows,",
             n_to_bin, n_to_bcd, n_ovf);
    $display("%0d drain pauses, byte counts 0 to 15, random stalls on both channels.",
             n_holds);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
